>>> sv/stt_pkg.sv
// Shared types, constants and score arithmetic for the search transposition table.
package stt_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 4096;

    localparam int unsigned KEY_W   = 64;
    localparam int unsigned MOVE_W  = 26;
    localparam int unsigned SCORE_W = 16;
    localparam int unsigned DEPTH_W = 6;
    localparam int unsigned PLY_W   = 6;
    localparam int unsigned BOUND_W = 2;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned THR_W   = 15;

    localparam logic [THR_W-1:0] THR_RESET = 15'd29936;

    // operation selector carried on the input tuser
    typedef enum logic [1:0] {
        MODE_PROBE = 2'd0,
        MODE_STORE = 2'd1,
        MODE_MOVE  = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    localparam int unsigned MODE_W = 2;

    // bound kinds as stored in an entry
    localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd0;
    localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd1;
    localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd2;

    // input tdata, first field in the lowest bits
    typedef struct packed {
        logic [BOUND_W-1:0]        new_bound_kind;
        logic signed [SCORE_W-1:0] new_score;
        logic [MOVE_W-1:0]         new_move;
        logic signed [SCORE_W-1:0] beta_bound;
        logic signed [SCORE_W-1:0] alpha_bound;
        logic [DEPTH_W-1:0]        search_depth;
        logic [PLY_W-1:0]          ply_from_root;
        logic [KEY_W-1:0]          position_key;
    } in_data_t;

    localparam int unsigned IN_DATA_W = $bits(in_data_t);

    localparam int unsigned OUT_PAD_W = 6;

    // output tdata, first field in the lowest bits, padded to whole bytes
    typedef struct packed {
        logic [OUT_PAD_W-1:0]      pad;
        logic [CNT_W-1:0]          overwrite_count;
        logic [CNT_W-1:0]          new_write_count;
        logic [CNT_W-1:0]          hit_count;
        logic signed [SCORE_W-1:0] found_score;
        logic [MOVE_W-1:0]         found_move;
    } out_data_t;

    localparam int unsigned OUT_DATA_W = $bits(out_data_t);

    // output tuser: cutoff in bit 0, key_matched in bit 1
    typedef struct packed {
        logic key_matched;
        logic cutoff;
    } out_user_t;

    localparam int unsigned OUT_USER_W = $bits(out_user_t);

    // one table entry as held in memory
    typedef struct packed {
        logic [KEY_W-1:0]          tag;
        logic [MOVE_W-1:0]         move;
        logic signed [SCORE_W-1:0] score;
        logic [DEPTH_W-1:0]        depth;
        logic [BOUND_W-1:0]        bound;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

    localparam logic signed [SCORE_W+1:0] SAT_MAX = 18'sd32767;
    localparam logic signed [SCORE_W+1:0] SAT_MIN = -18'sd32768;

    // Shift a mate score by ply, away from zero on store, toward zero on probe.
    function automatic logic signed [SCORE_W-1:0] mate_adjust(
        input logic signed [SCORE_W-1:0] score,
        input logic [THR_W-1:0]          thr,
        input logic [PLY_W-1:0]          ply,
        input logic                      toward_zero
    );
        logic signed [SCORE_W+1:0] s;
        logic signed [SCORE_W+1:0] t;
        logic signed [SCORE_W+1:0] p;
        logic signed [SCORE_W+1:0] sum;
        logic signed [SCORE_W-1:0] res;
        s = {{2{score[SCORE_W-1]}}, score};
        t = {3'b000, thr};
        p = {{(SCORE_W+2-PLY_W){1'b0}}, ply};
        if (s > t)
        begin
            sum = toward_zero ? s - p : s + p;
        end
        else if (s < -t)
        begin
            sum = toward_zero ? s + p : s - p;
        end
        else
        begin
            sum = s;
        end
        if (sum > SAT_MAX)
        begin
            res = SAT_MAX[SCORE_W-1:0];
        end
        else if (sum < SAT_MIN)
        begin
            res = SAT_MIN[SCORE_W-1:0];
        end
        else
        begin
            res = sum[SCORE_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> sv/stt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module stt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/stt_index.sv
// Entry index from the position key: a mask for power-of-two tables, else a residue sum.
module stt_index #(
    parameter int unsigned TABLE_ENTRIES = stt_pkg::TABLE_ENTRIES_DEF,
    parameter int unsigned IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [stt_pkg::KEY_W-1:0] key,
    output logic [IDX_W-1:0]         idx,
    output logic                     done
);

    import stt_pkg::*;

    localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

    // residue of each key bit weight modulo the table size, IDX_W bits per key bit
    function automatic logic [KEY_W*IDX_W-1:0] bit_residues();
        logic [KEY_W*IDX_W-1:0] tab;
        longint unsigned        r;
        tab = '0;
        r   = 1;
        for (int j = 0; j < KEY_W; j++)
        begin
            r = r % TABLE_ENTRIES;
            tab[j*IDX_W +: IDX_W] = IDX_W'(r);
            r = r * 2;
        end
        return tab;
    endfunction

    generate
        if (IS_POW2)
        begin : g_mask
            // modulo by a power of two: take the low key bits at once
            assign idx  = key[IDX_W-1:0];
            assign done = start;
        end
        else
        begin : g_resid
            localparam int unsigned CHUNK_W = 16;
            localparam int unsigned CHUNKS  = KEY_W / CHUNK_W;
            localparam int unsigned ACC_W   = IDX_W + 6;
            localparam int unsigned STEP_W  = 3;
            localparam logic [STEP_W-1:0] LAST_SUM  = STEP_W'(CHUNKS - 1);
            localparam logic [STEP_W-1:0] HIGH_FOLD = STEP_W'(CHUNKS);
            localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CHUNKS + 1);
            localparam logic [ACC_W-1:0]  MOD_ACC   = ACC_W'(TABLE_ENTRIES);
            localparam logic [KEY_W*IDX_W-1:0] BIT_RES = bit_residues();

            logic               busy_reg, busy_next;
            logic               done_reg, done_next;
            logic [STEP_W-1:0]  step_reg, step_next;
            logic [KEY_W-1:0]   key_reg, key_next;
            logic [ACC_W-1:0]   acc_reg, acc_next;
            logic [ACC_W-1:0]   chunk_sum;
            logic [ACC_W-1:0]   fold;

            // add the residues of the set bits among the low sixteen key bits as a tree
            always_comb
            begin
                logic [ACC_W-1:0] node [2*CHUNK_W];
                int               base;
                node[0] = '0;
                for (int b = 0; b < CHUNK_W; b++)
                begin
                    base = (int'(step_reg[1:0]) * CHUNK_W + b) * IDX_W;
                    node[CHUNK_W + b] = key_reg[b] ? ACC_W'(BIT_RES[base +: IDX_W]) : '0;
                end
                for (int i = CHUNK_W - 1; i > 0; i--)
                begin
                    node[i] = node[2*i] + node[2*i+1];
                end
                chunk_sum = node[1];
            end

            // bring the sum below the table size: 32, 16 and 8 times it first, then 4, 2 and 1
            always_comb
            begin
                logic [ACC_W-1:0] lim;
                fold = acc_reg;
                for (int k = 2; k >= 0; k--)
                begin
                    lim = (step_reg == HIGH_FOLD) ? (MOD_ACC << (k + 3)) : (MOD_ACC << k);
                    if (fold >= lim)
                    begin
                        fold = fold - lim;
                    end
                end
            end

            always_comb
            begin
                busy_next = busy_reg;
                done_next = 1'b0;
                step_next = step_reg;
                key_next  = key_reg;
                acc_next  = acc_reg;
                if (start)
                begin
                    busy_next = 1'b1;
                    step_next = '0;
                    key_next  = key;
                    acc_next  = '0;
                end
                else if (busy_reg)
                begin
                    step_next = step_reg + 1'b1;
                    if (step_reg <= LAST_SUM)
                    begin
                        acc_next = acc_reg + chunk_sum;
                        key_next = key_reg >> CHUNK_W;
                    end
                    else
                    begin
                        acc_next = fold;
                        if (step_reg == LAST_STEP)
                        begin
                            busy_next = 1'b0;
                            done_next = 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                    step_reg <= '0;
                end
                else
                begin
                    busy_reg <= busy_next;
                    done_reg <= done_next;
                    step_reg <= step_next;
                end
            end

            always_ff @(posedge clk)
            begin
                key_reg <= key_next;
                acc_reg <= acc_next;
            end

            assign idx  = acc_reg[IDX_W-1:0];
            assign done = done_reg;
        end
    endgenerate

endmodule

>>> sv/search_transposition_table.sv
// Search transposition table: direct-mapped entry memory with probe, move lookup, store and clear.
// Flow: when TABLE_ENTRIES is a power of two, a probe or store issues its memory read on accept,
//   then is evaluated and written back; else the key reduction first sums bit residues chunk by
//   chunk and folds the sum below the table size. One item is in flight at a time.
// A clear item sweeps the entry memory one entry a cycle, then returns a result.
// Reset: counters and control clear at once, then a sweep zeroes every entry of memory.
module search_transposition_table #(
    parameter int unsigned TABLE_ENTRIES = stt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration: mate_threshold
    input  logic                          cfg_we,
    input  logic [stt_pkg::THR_W-1:0]     cfg_wdata,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // position_key, ply_from_root, search_depth, alpha_bound, beta_bound,
    // new_move, new_score, new_bound_kind
    input  logic [stt_pkg::IN_DATA_W-1:0] s_tdata,
    // mode
    input  logic [stt_pkg::MODE_W-1:0]    s_tuser,
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // found_move, found_score, hit_count, new_write_count, overwrite_count, zero pad
    output logic [stt_pkg::OUT_DATA_W-1:0] m_tdata,
    // cutoff, key_matched
    output logic [stt_pkg::OUT_USER_W-1:0] m_tuser
);

    import stt_pkg::*;

    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [3:0] {
        ST_SWEEP = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_INDEX = 4'b0100,
        ST_EVAL  = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     sweep_cnt_reg, sweep_cnt_next;
    logic                 clr_item_reg, clr_item_next;
    logic [THR_W-1:0]     thr_reg;

    // captured item
    mode_t                mode_reg;
    in_data_t             item_reg;
    logic [IDX_W-1:0]     idx_reg;

    // counters, shown on the result port after each transaction's update
    logic [CNT_W-1:0]     hits_reg, hits_next;
    logic [CNT_W-1:0]     fresh_reg, fresh_next;
    logic [CNT_W-1:0]     repl_reg, repl_next;

    // output register
    logic                 m_tvalid_reg, m_tvalid_next;
    out_user_t            out_user_reg, out_user_next;
    logic [MOVE_W-1:0]    out_move_reg, out_move_next;
    logic [SCORE_W-1:0]   out_score_reg, out_score_next;

    // memory port
    logic                 ram_we, ram_re;
    logic [IDX_W-1:0]     ram_waddr;
    entry_t               ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    entry_t               rd_entry;

    // index unit
    logic [IDX_W-1:0]     idx;
    logic                 idx_done;
    logic                 idx_start;

    in_data_t             in_item;
    mode_t                in_mode;
    logic                 s_accept;
    logic                 out_free;

    // evaluation results
    logic                 res_cut, res_match;
    logic [MOVE_W-1:0]    res_move;
    logic [SCORE_W-1:0]   res_score;
    logic                 res_hit;
    entry_t               store_entry;

    assign in_item   = in_data_t'(s_tdata);
    assign in_mode   = mode_t'(s_tuser);
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign idx_start = s_accept && (in_mode != MODE_CLEAR);
    assign rd_entry  = entry_t'(ram_rdata);

    stt_index #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_index (
        .clk   (clk),
        .rst_n (rst_n),
        .start (idx_start),
        .key   (in_item.position_key),
        .idx   (idx),
        .done  (idx_done)
    );

    stt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES),
        .AW    (IDX_W)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx),
        .rdata (ram_rdata)
    );

    // Evaluate the entry read for the held item. The write-back of a store lands
    // before the next item's read is issued, so no forwarding is needed.
    always_comb
    begin
        logic signed [SCORE_W-1:0] adj;
        logic                      tag_eq;
        res_cut   = 1'b0;
        res_match = 1'b0;
        res_move  = '0;
        res_score = '0;
        res_hit   = 1'b0;
        tag_eq    = (rd_entry.tag == item_reg.position_key);
        adj       = mate_adjust(rd_entry.score, thr_reg, item_reg.ply_from_root, 1'b1);

        store_entry.tag   = item_reg.position_key;
        store_entry.move  = item_reg.new_move;
        store_entry.score = mate_adjust(item_reg.new_score, thr_reg,
                                        item_reg.ply_from_root, 1'b0);
        store_entry.depth = item_reg.search_depth;
        store_entry.bound = item_reg.new_bound_kind;

        case (mode_reg)
            MODE_STORE:
            begin
                res_match = tag_eq;
            end
            MODE_PROBE, MODE_MOVE:
            begin
                if (tag_eq)
                begin
                    res_match = 1'b1;
                    res_move  = rd_entry.move;
                    if ((mode_reg == MODE_PROBE) && (rd_entry.depth >= item_reg.search_depth))
                    begin
                        res_hit   = 1'b1;
                        res_score = adj;
                        case (rd_entry.bound)
                            BOUND_UPPER:
                            begin
                                if (adj <= item_reg.alpha_bound)
                                begin
                                    res_score = item_reg.alpha_bound;
                                    res_cut   = 1'b1;
                                end
                            end
                            BOUND_LOWER:
                            begin
                                if (adj >= item_reg.beta_bound)
                                begin
                                    res_score = item_reg.beta_bound;
                                    res_cut   = 1'b1;
                                end
                            end
                            BOUND_EXACT:
                            begin
                                res_cut = 1'b1;
                            end
                            default:
                            begin
                                res_cut = 1'b0;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                res_match = 1'b0;
            end
        endcase
    end

    // Sequencer: sweep, accept, reduce key, read, evaluate and write back.
    always_comb
    begin
        state_next     = state_reg;
        sweep_cnt_next = sweep_cnt_reg;
        clr_item_next  = clr_item_reg;
        ram_re         = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = store_entry;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        out_user_next  = out_user_reg;
        out_move_next  = out_move_reg;
        out_score_next = out_score_reg;
        hits_next      = hits_reg;
        fresh_next     = fresh_reg;
        repl_next      = repl_reg;

        case (state_reg)
            ST_SWEEP:
            begin
                // zero one entry a cycle
                ram_we    = 1'b1;
                ram_waddr = sweep_cnt_reg;
                ram_wdata = '0;
                if (sweep_cnt_reg == LAST_ENTRY)
                begin
                    sweep_cnt_next = '0;
                    state_next     = clr_item_reg ? ST_EVAL : ST_IDLE;
                end
                else
                begin
                    sweep_cnt_next = sweep_cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (in_mode == MODE_CLEAR)
                    begin
                        clr_item_next = 1'b1;
                        state_next    = ST_SWEEP;
                    end
                    else if (idx_done)
                    begin
                        ram_re     = 1'b1;
                        state_next = ST_EVAL;
                    end
                    else
                    begin
                        state_next = ST_INDEX;
                    end
                end
            end
            ST_INDEX:
            begin
                if (idx_done)
                begin
                    ram_re     = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                // hold here while the previous result is still waiting
                if (out_free)
                begin
                    state_next    = ST_IDLE;
                    clr_item_next = 1'b0;
                    m_tvalid_next = 1'b1;
                    out_user_next.cutoff      = res_cut;
                    out_user_next.key_matched = res_match;
                    out_move_next  = res_move;
                    out_score_next = res_score;
                    case (mode_reg)
                        MODE_STORE:
                        begin
                            ram_we = 1'b1;
                            if (rd_entry.tag == '0)
                            begin
                                fresh_next = fresh_reg + 1'b1;
                            end
                            else
                            begin
                                repl_next = repl_reg + 1'b1;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            fresh_next = '0;
                        end
                        default:
                        begin
                            if (res_hit)
                            begin
                                hits_next = hits_reg + 1'b1;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_cnt_reg <= '0;
            clr_item_reg  <= 1'b0;
            thr_reg       <= THR_RESET;
            hits_reg      <= '0;
            fresh_reg     <= '0;
            repl_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            clr_item_reg  <= clr_item_next;
            hits_reg      <= hits_next;
            fresh_reg     <= fresh_next;
            repl_reg      <= repl_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
        end
    end

    // payload registers: capture the item on accept, the entry index on read
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            mode_reg <= in_mode;
            item_reg <= in_item;
        end
        if (ram_re)
        begin
            idx_reg <= idx;
        end
        out_user_reg  <= out_user_next;
        out_move_reg  <= out_move_next;
        out_score_reg <= out_score_next;
    end

    // counters only move when a result is loaded, so they match the waiting result
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_user_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, repl_reg, fresh_reg, hits_reg,
                       out_score_reg, out_move_reg};

endmodule
